FILE: hw/rtl/obsi_pkg.sv
// Shared types for the order book sorted insert block.
package obsi_pkg;

  typedef enum logic {
    SIDE_BUY  = 1'b0,
    SIDE_SELL = 1'b1
  } side_t;

  // Per-cycle control broadcast from the top level to every cell.
  typedef struct packed {
    logic  write;    // an accepted order is inserted this cycle
    side_t side;     // book addressed by the order
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/obsi_order_if.sv
// Order request channel: side, price and id of one new order.
interface obsi_order_if #(
  parameter int PRICE_BITS = 32,
  parameter int ID_BITS    = 32
);
  logic                  valid;
  logic                  ready;
  logic                  sell_side;
  logic [PRICE_BITS-1:0] price;
  logic [ID_BITS-1:0]    order_id;

  modport source (output valid, sell_side, price, order_id, input ready);
  modport sink   (input valid, sell_side, price, order_id, output ready);
endinterface

FILE: hw/rtl/obsi_result_if.sv
// Result request channel: rank, new count and full flag of one order.
interface obsi_result_if #(
  parameter int RANK_BITS  = 6,
  parameter int COUNT_BITS = 7
);
  logic                  valid;
  logic                  ready;
  logic                  sell_side_res;
  logic [RANK_BITS-1:0]  rank;
  logic [COUNT_BITS-1:0] book_count;
  logic                  book_full;

  modport source (output valid, sell_side_res, rank, book_count, book_full, input ready);
  modport sink   (input valid, sell_side_res, rank, book_count, book_full, output ready);
endinterface

FILE: hw/rtl/obsi_cell.sv
// One book position: holds the buy and sell entry at this rank.
module obsi_cell #(
  parameter int PRICE_BITS = 32,
  parameter int ID_BITS    = 32
) (
  input  logic                   clk,
  input  obsi_pkg::cell_ctrl_t   ctrl,
  input  logic                   in_book,
  input  logic [PRICE_BITS-1:0]  new_price,
  input  logic [ID_BITS-1:0]     new_id,
  input  logic                   prev_ahead,
  input  logic [PRICE_BITS-1:0]  prev_buy_price,
  input  logic [ID_BITS-1:0]     prev_buy_id,
  input  logic [PRICE_BITS-1:0]  prev_sell_price,
  input  logic [ID_BITS-1:0]     prev_sell_id,
  output logic                   ahead,
  output logic [PRICE_BITS-1:0]  buy_price,
  output logic [ID_BITS-1:0]     buy_id,
  output logic [PRICE_BITS-1:0]  sell_price,
  output logic [ID_BITS-1:0]     sell_id
);

  logic                  is_sell;
  logic [PRICE_BITS-1:0] cur_price;
  logic [ID_BITS-1:0]    cur_id;
  logic                  better;

  assign is_sell   = (ctrl.side == obsi_pkg::SIDE_SELL);
  assign cur_price = is_sell ? sell_price : buy_price;
  assign cur_id    = is_sell ? sell_id : buy_id;

  // The stored entry stays ahead of the new order on better price, or on
  // equal price with a strictly lower id.
  always_comb begin
    if (cur_price == new_price) begin
      better = (cur_id < new_id);
    end else if (is_sell) begin
      better = (cur_price < new_price);
    end else begin
      better = (cur_price > new_price);
    end
  end

  assign ahead = in_book && better;

  // Entries that are not ahead move back one place; the first of them
  // takes the new order instead.
  always_ff @(posedge clk) begin
    if (ctrl.write && !ahead) begin
      if (is_sell) begin
        sell_price <= prev_ahead ? new_price : prev_sell_price;
        sell_id    <= prev_ahead ? new_id : prev_sell_id;
      end else begin
        buy_price  <= prev_ahead ? new_price : prev_buy_price;
        buy_id     <= prev_ahead ? new_id : prev_buy_id;
      end
    end
  end

endmodule

FILE: hw/rtl/order_book_sorted_insert.sv
// Top level of the order book sorted insert block.
//
//   channel | direction | payload
//   --------+-----------+------------------------------------------
//   order   | in        | sell_side, price, order_id
//   res     | out       | sell_side_res, rank, book_count, book_full
//
// Unless stalled, one order is taken per cycle; its result is registered
// and shows in the cycle after acceptance. Every cell compares its own entry
// with the new order in the same cycle and shifts or loads locally, so the
// book is ready for the next order on the following edge. order.ready is low
// only while a result waits and res.ready is low. Reset empties both books.
module order_book_sorted_insert #(
  parameter int BOOK_DEPTH = 64,
  parameter int PRICE_BITS = 32,
  parameter int ID_BITS    = 32
) (
  input  logic           clk,
  input  logic           rst,
  obsi_order_if.sink     order,
  obsi_result_if.source  res
);

  localparam int RANK_BITS  = $clog2(BOOK_DEPTH);
  localparam int COUNT_BITS = $clog2(BOOK_DEPTH + 1);

  logic [COUNT_BITS-1:0] buy_count;
  logic [COUNT_BITS-1:0] sell_count;
  logic [COUNT_BITS-1:0] sel_count;
  logic                  take;
  logic                  full;
  obsi_pkg::cell_ctrl_t  ctrl;

  logic [BOOK_DEPTH-1:0] ahead;
  logic [BOOK_DEPTH-1:0] prev_ahead;
  logic [BOOK_DEPTH-1:0] hit;
  logic [RANK_BITS-1:0]  rank_enc;

  logic [PRICE_BITS-1:0] buy_price  [BOOK_DEPTH];
  logic [ID_BITS-1:0]    buy_id     [BOOK_DEPTH];
  logic [PRICE_BITS-1:0] sell_price [BOOK_DEPTH];
  logic [ID_BITS-1:0]    sell_id    [BOOK_DEPTH];

  assign order.ready = !res.valid || res.ready;
  assign take        = order.valid && order.ready;

  assign sel_count = order.sell_side ? sell_count : buy_count;
  assign full      = (sel_count == COUNT_BITS'(BOOK_DEPTH));

  assign ctrl.write = take && !full;
  assign ctrl.side  = obsi_pkg::side_t'(order.sell_side);

  genvar g;
  generate
    for (g = 0; g < BOOK_DEPTH; g++) begin : g_cell
      logic in_book;
      assign in_book = (COUNT_BITS'(g) < sel_count);

      if (g == 0) begin : g_head
        assign prev_ahead[g] = 1'b1;
        obsi_cell #(.PRICE_BITS(PRICE_BITS), .ID_BITS(ID_BITS)) u_cell (
          .clk             (clk),
          .ctrl            (ctrl),
          .in_book         (in_book),
          .new_price       (order.price),
          .new_id          (order.order_id),
          .prev_ahead      (prev_ahead[g]),
          .prev_buy_price  (order.price),
          .prev_buy_id     (order.order_id),
          .prev_sell_price (order.price),
          .prev_sell_id    (order.order_id),
          .ahead           (ahead[g]),
          .buy_price       (buy_price[g]),
          .buy_id          (buy_id[g]),
          .sell_price      (sell_price[g]),
          .sell_id         (sell_id[g])
        );
      end else begin : g_body
        assign prev_ahead[g] = ahead[g-1];
        obsi_cell #(.PRICE_BITS(PRICE_BITS), .ID_BITS(ID_BITS)) u_cell (
          .clk             (clk),
          .ctrl            (ctrl),
          .in_book         (in_book),
          .new_price       (order.price),
          .new_id          (order.order_id),
          .prev_ahead      (prev_ahead[g]),
          .prev_buy_price  (buy_price[g-1]),
          .prev_buy_id     (buy_id[g-1]),
          .prev_sell_price (sell_price[g-1]),
          .prev_sell_id    (sell_id[g-1]),
          .ahead           (ahead[g]),
          .buy_price       (buy_price[g]),
          .buy_id          (buy_id[g]),
          .sell_price      (sell_price[g]),
          .sell_id         (sell_id[g])
        );
      end
    end
  endgenerate

  // Entries ahead of the order form a prefix, so exactly one cell sees the
  // boundary whenever the book has room.
  assign hit = prev_ahead & ~ahead;

  always_comb begin
    rank_enc = '0;
    for (int i = 0; i < BOOK_DEPTH; i++) begin
      if (hit[i]) begin
        rank_enc = rank_enc | RANK_BITS'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buy_count  <= '0;
      sell_count <= '0;
      res.valid  <= 1'b0;
    end else begin
      if (ctrl.write) begin
        if (order.sell_side) begin
          sell_count <= sell_count + COUNT_BITS'(1);
        end else begin
          buy_count <= buy_count + COUNT_BITS'(1);
        end
      end
      if (take) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res.sell_side_res <= order.sell_side;
      res.rank          <= full ? '0 : rank_enc;
      res.book_count    <= full ? sel_count : sel_count + COUNT_BITS'(1);
      res.book_full     <= full;
    end
  end

endmodule

FILE: hw/rtl/obsi_checker.sv
// Port-level assertions for the order book sorted insert block, with bind.
module obsi_checker #(
  parameter int BOOK_DEPTH = 64
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             res_valid,
  input logic                             res_ready,
  input logic [$clog2(BOOK_DEPTH)-1:0]    rank,
  input logic [$clog2(BOOK_DEPTH+1)-1:0]  book_count,
  input logic                             book_full
);

  localparam int COUNT_BITS = $clog2(BOOK_DEPTH + 1);

  // A refused order reports a full book and the fixed rank.
  a_full_result: assert property (@(posedge clk) disable iff (rst)
    res_valid && book_full |-> book_count == COUNT_BITS'(BOOK_DEPTH) && rank == '0)
    else $error("full result with wrong count or rank");

  // An inserted order lands inside the book it grew.
  a_rank_in_book: assert property (@(posedge clk) disable iff (rst)
    res_valid && !book_full |-> book_count != '0 && COUNT_BITS'(rank) < book_count)
    else $error("rank outside the book");

  // A result waiting on the sink holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(rank) && $stable(book_count)
      && $stable(book_full))
    else $error("waiting result changed");

  // Nothing is reported in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind order_book_sorted_insert obsi_checker #(.BOOK_DEPTH(BOOK_DEPTH)) u_obsi_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .rank       (res.rank),
  .book_count (res.book_count),
  .book_full  (res.book_full)
);

FILE: tb/order_book_sorted_insert_test.sv
// Self-checking testbench for the two-sided sorted order book insert block.
module order_book_sorted_insert_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BOOK_DEPTH  = 64;
  localparam int PRICE_BITS  = 32;
  localparam int ID_BITS     = 32;
  localparam int ORDER_TOTAL = 900;
  localparam int FILL_TARGET = BOOK_DEPTH + 6;
  localparam int HOLDOFF_LEN = 300;
  localparam int STUCK_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [PRICE_BITS-1:0] price;
    logic [ID_BITS-1:0]    id;
  } book_entry_t;

  typedef struct packed {
    logic       sell_side;
    logic [5:0] rank;
    logic [6:0] count;
    logic       full;
  } placement_t;

  logic clk = 1'b0;
  logic rst;

  obsi_order_if #(.PRICE_BITS(PRICE_BITS), .ID_BITS(ID_BITS)) order ();
  obsi_result_if #(.RANK_BITS(6), .COUNT_BITS(7)) res ();

  order_book_sorted_insert #(
    .BOOK_DEPTH(BOOK_DEPTH),
    .PRICE_BITS(PRICE_BITS),
    .ID_BITS(ID_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .order(order),
    .res(res)
  );

  always #4 clk = ~clk;

  // Shadow copy of both books: index 0 is the buy book, 1 the sell book.
  book_entry_t book [2][BOOK_DEPTH];
  int          book_fill [2];
  placement_t  due_placements [$];

  int sent [2];
  int orders_sent;
  int burst_left;
  bit sender_steady;
  bit receiver_steady;
  int holdoff_len;
  int mismatches;
  int placed_seen;
  int refused_seen;
  int stuck_cycles;

  function automatic bit entry_ahead(obsi_pkg::side_t side, book_entry_t e,
                                     logic [PRICE_BITS-1:0] p, logic [ID_BITS-1:0] id);
    if (e.price == p) return e.id < id;
    if (side == obsi_pkg::SIDE_SELL) return e.price < p;
    return e.price > p;
  endfunction

  function automatic placement_t predict_insert(obsi_pkg::side_t side,
                                                logic [PRICE_BITS-1:0] p,
                                                logic [ID_BITS-1:0] id);
    placement_t outcome;
    int s;
    int pos;
    s = (side == obsi_pkg::SIDE_SELL) ? 1 : 0;
    outcome = '0;
    outcome.sell_side = side;
    if (book_fill[s] >= BOOK_DEPTH) begin
      outcome.full = 1'b1;
      outcome.count = 7'(BOOK_DEPTH);
      return outcome;
    end
    pos = 0;
    for (int i = 0; i < book_fill[s]; i++)
      if (entry_ahead(side, book[s][i], p, id)) pos++;
    for (int i = book_fill[s]; i > pos; i--)
      book[s][i] = book[s][i-1];
    book[s][pos] = '{price: p, id: id};
    book_fill[s]++;
    outcome.rank = 6'(pos);
    outcome.count = 7'(book_fill[s]);
    return outcome;
  endfunction

  function automatic logic [PRICE_BITS-1:0] pick_price();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return PRICE_BITS'($urandom_range(0, 3));
      2: return '1 - PRICE_BITS'($urandom_range(0, 3));
      default: return PRICE_BITS'(1000 + $urandom_range(0, 7));
    endcase
  endfunction

  // Small ids give plenty of exact ties; the all-ones id is kept for the worst-rank order.
  function automatic logic [ID_BITS-1:0] pick_id();
    logic [ID_BITS-1:0] id;
    if ($urandom_range(0, 1) == 0) id = ID_BITS'($urandom_range(0, 7));
    else id = $urandom();
    if (id == '1) id = '0;
    return id;
  endfunction

  task automatic flag_mismatch(string field, longint unsigned want, longint unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("Mismatch on %s: expected %0d, got %0d", field, want, got);
  endtask

  // Requests are accepted where the predictor sees them, so the order of
  // expectations always follows the order of acceptance.
  always @(posedge clk) begin
    if (!rst && order.valid && order.ready)
      due_placements.push_back(predict_insert(obsi_pkg::side_t'(order.sell_side),
                                              order.price, order.order_id));
  end

  always @(posedge clk) begin
    placement_t want;
    if (!rst && res.valid && res.ready) begin
      if (due_placements.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Result arrived with no order pending");
      end else begin
        want = due_placements.pop_front();
        if (want.full) refused_seen++;
        else placed_seen++;
        if (res.sell_side_res !== want.sell_side)
          flag_mismatch("sell_side_res", want.sell_side, res.sell_side_res);
        if (res.rank !== want.rank) flag_mismatch("rank", want.rank, res.rank);
        if (res.book_count !== want.count)
          flag_mismatch("book_count", want.count, res.book_count);
        if (res.book_full !== want.full)
          flag_mismatch("book_full", want.full, res.book_full);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (order.valid && order.ready) || (res.valid && res.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Timed out with %0d results outstanding", due_placements.size());
      $display("[order_book_sorted_insert] ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Receiver: alternating runs of ready and stall, unless told to stay open
  // or to hold off for a long stretch.
  initial begin : receiver
    int run;
    bit open;
    run = 0;
    open = 1'b1;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_len > 0) begin
        res.ready <= 1'b0;
        holdoff_len--;
      end else if (receiver_steady) begin
        res.ready <= 1'b1;
      end else begin
        if (run == 0) begin
          open = !open;
          run = open ? $urandom_range(1, 10) : $urandom_range(1, 6);
        end
        run--;
        res.ready <= open;
      end
    end
  end

  task automatic send_order(obsi_pkg::side_t side, logic [PRICE_BITS-1:0] p,
                            logic [ID_BITS-1:0] id);
    int gap;
    if (!sender_steady && burst_left == 0) begin
      gap = $urandom_range(1, 12);
      order.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    if (burst_left > 0) burst_left--;
    order.valid <= 1'b1;
    order.sell_side <= side;
    order.price <= p;
    order.order_id <= id;
    @(posedge clk);
    while (!order.ready) @(posedge clk);
    sent[side == obsi_pkg::SIDE_SELL ? 1 : 0]++;
    orders_sent++;
  endtask

  task automatic pause_sender();
    order.valid <= 1'b0;
    burst_left = 0;
  endtask

  // The task waits on the clock first so that the last accepted request is already queued.
  task automatic wait_drained();
    pause_sender();
    @(posedge clk);
    while (due_placements.size() != 0) @(posedge clk);
  endtask

  task automatic send_random(obsi_pkg::side_t side);
    send_order(side, pick_price(), pick_id());
  endtask

  // Extremes of price and id on the buy book, with repeated prices for the id tie-break.
  task automatic test_buy_extremes();
    send_order(obsi_pkg::SIDE_BUY, 32'd100, 32'd5);
    send_order(obsi_pkg::SIDE_BUY, 32'd100, 32'd3);
    send_order(obsi_pkg::SIDE_BUY, 32'd100, 32'd7);
    send_order(obsi_pkg::SIDE_BUY, 32'd100, 32'd5);
    send_order(obsi_pkg::SIDE_BUY, 32'hffff_ffff, 32'd0);
    send_order(obsi_pkg::SIDE_BUY, 32'd0, 32'hffff_fffe);
    send_order(obsi_pkg::SIDE_BUY, 32'd100, 32'd0);
    send_order(obsi_pkg::SIDE_BUY, 32'd100, 32'hffff_ffff);
    send_order(obsi_pkg::SIDE_BUY, 32'd0, 32'd0);
    send_order(obsi_pkg::SIDE_BUY, 32'hffff_ffff, 32'hffff_fffe);
    send_order(obsi_pkg::SIDE_BUY, 32'h8000_0000, 32'h1234_5678);
    send_order(obsi_pkg::SIDE_BUY, 32'h7fff_ffff, 32'ha5a5_a5a5);
  endtask

  task automatic test_sell_extremes();
    send_order(obsi_pkg::SIDE_SELL, 32'd100, 32'd5);
    send_order(obsi_pkg::SIDE_SELL, 32'd100, 32'd3);
    send_order(obsi_pkg::SIDE_SELL, 32'd100, 32'd7);
    send_order(obsi_pkg::SIDE_SELL, 32'd100, 32'd5);
    send_order(obsi_pkg::SIDE_SELL, 32'hffff_ffff, 32'hffff_fffe);
    send_order(obsi_pkg::SIDE_SELL, 32'd0, 32'hffff_ffff);
    send_order(obsi_pkg::SIDE_SELL, 32'd100, 32'd0);
    send_order(obsi_pkg::SIDE_SELL, 32'd100, 32'hffff_ffff);
    send_order(obsi_pkg::SIDE_SELL, 32'd0, 32'd0);
    send_order(obsi_pkg::SIDE_SELL, 32'hffff_ffff, 32'd0);
    send_order(obsi_pkg::SIDE_SELL, 32'h8000_0000, 32'h5a5a_5a5a);
    send_order(obsi_pkg::SIDE_SELL, 32'h7fff_ffff, 32'h1234_5678);
  endtask

  // The receiver holds off while orders keep coming back to back, so the
  // block must stall its input once a result is waiting.
  task automatic test_receiver_holdoff();
    sender_steady = 1'b1;
    holdoff_len = HOLDOFF_LEN;
    repeat (40) send_random(obsi_pkg::side_t'($urandom_range(0, 1)));
    sender_steady = 1'b0;
  endtask

  task automatic test_drain_pause();
    wait_drained();
    repeat (6) send_random(obsi_pkg::side_t'($urandom_range(0, 1)));
  endtask

  // Fill both books past their depth. The last order to fit each book is
  // the worst possible one, so it lands at the back.
  task automatic test_fill_books();
    obsi_pkg::side_t side;
    int s;
    receiver_steady = 1'b1;
    sender_steady = 1'b1;
    repeat (20) send_random(obsi_pkg::side_t'($urandom_range(0, 1)));
    receiver_steady = 1'b0;
    sender_steady = 1'b0;
    while (sent[0] < FILL_TARGET || sent[1] < FILL_TARGET) begin
      if (sent[0] >= FILL_TARGET) side = obsi_pkg::SIDE_SELL;
      else if (sent[1] >= FILL_TARGET) side = obsi_pkg::SIDE_BUY;
      else side = obsi_pkg::side_t'($urandom_range(0, 1));
      s = (side == obsi_pkg::SIDE_SELL) ? 1 : 0;
      if (sent[s] == BOOK_DEPTH - 1)
        send_order(side, (side == obsi_pkg::SIDE_SELL) ? '1 : '0, '1);
      else
        send_random(side);
    end
  endtask

  // Both books are full now: every further order must be refused.
  task automatic test_full_books();
    while (orders_sent < ORDER_TOTAL) begin
      if (orders_sent % 200 == 0) begin
        receiver_steady = ($urandom_range(0, 2) == 0);
        sender_steady = ($urandom_range(0, 2) == 0);
      end
      if (orders_sent % 300 == 0) wait_drained();
      send_order(obsi_pkg::side_t'($urandom_range(0, 1)), $urandom(), $urandom());
    end
    sender_steady = 1'b0;
    receiver_steady = 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    order.valid <= 1'b0;
    order.sell_side <= 1'b0;
    order.price <= '0;
    order.order_id <= '0;
    book_fill = '{0, 0};
    sent = '{0, 0};
    orders_sent = 0;
    burst_left = 0;
    sender_steady = 1'b0;
    receiver_steady = 1'b0;
    holdoff_len = 0;
    mismatches = 0;
    placed_seen = 0;
    refused_seen = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_buy_extremes();
    test_sell_extremes();
    test_receiver_holdoff();
    test_drain_pause();
    test_fill_books();
    test_full_books();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d orders: %0d placed into a book and %0d refused by a full book,",
             orders_sent, placed_seen, refused_seen);
    $display("with ties on price and id, a %0d-cycle receiver hold-off and drained pauses.",
             HOLDOFF_LEN);
    if (mismatches == 0 && due_placements.size() == 0) begin
      $display("[order_book_sorted_insert] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, due_placements.size());
      $display("[order_book_sorted_insert] ERROR");
    end
    $finish;
  end

endmodule
